/* rtl/xlb_pkg.sv */
// package: command codes and widths shared by the xor linear basis block
`default_nettype none

package xlb_pkg;

  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

endpackage

`default_nettype wire

/* rtl/xlb_if.sv */
// interfaces: command channel and result channel of the xor linear basis block
`default_nettype none

interface xlb_req_if import xlb_pkg::*; #(
  parameter int W = 21
);
  logic             valid;
  logic             ready;
  logic [CMD_W-1:0] command;
  logic [W-1:0]     value;

  modport source (output valid, output command, output value, input ready);
  modport sink   (input valid, input command, input value, output ready);
endinterface

interface xlb_rsp_if #(
  parameter int W = 21
);
  logic         valid;
  logic         ready;
  logic [W-1:0] max_xor;

  modport source (output valid, output max_xor, input ready);
  modport sink   (input valid, input max_xor, output ready);
endinterface

`default_nettype wire

/* rtl/xlb_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module xlb_ram #(
  parameter int WIDTH = 21,
  parameter int DEPTH = 21,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* rtl/xor_linear_basis.sv */
// top level: gf(2) linear basis in a ram, with insert, max-xor query and clear
//
//   channel  dir  fields              transfer
//   req      in   command, value      req.valid && req.ready
//   rsp      out  max_xor             rsp.valid && rsp.ready
//
// insert and query walk the basis ram from the top slot down, one slot per cycle;
// an insert that lands in a high slot ends its walk there, before the lowest slot.
// clear and the unused command are handled in idle with no walk; clear drops per-slot valid flags.
// reset empties the basis at once (valid flags in flops) and idles the sequencer.
// a finished query result sits in the output register; the next command is taken
// while it waits, and a query walk only stalls at its end if that register is full.
`default_nettype none

module xor_linear_basis import xlb_pkg::*; #(
  parameter int VALUE_BITS = 21
) (
  input  wire logic  clk,
  input  wire logic  rst,
  xlb_req_if.sink    req,
  xlb_rsp_if.source  rsp
);

  localparam int IW = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam logic [IW-1:0] TOP = IW'(VALUE_BITS - 1);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_HOLD = 3'b100
  } state_t;

  state_t                state;
  logic [IW-1:0]         idx;
  logic                  op_query;
  logic [VALUE_BITS-1:0] acc;
  logic [VALUE_BITS-1:0] slot_valid;
  logic                  out_valid;
  logic [VALUE_BITS-1:0] out_data;

  logic                  accept;
  logic                  out_free;
  logic                  out_load;
  logic [IW-1:0]         rd_addr;
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] slot;
  logic                  wr_en;
  logic [VALUE_BITS-1:0] acc_next;
  logic                  walk_done;

  assign req.ready   = (state == S_IDLE);
  assign accept      = req.valid && req.ready;
  assign rsp.valid   = out_valid;
  assign rsp.max_xor = out_data;
  assign out_free    = !out_valid || rsp.ready;

  // a query result enters the output register at the end of its walk or out of hold
  assign out_load = ((state == S_WALK) && walk_done && op_query && out_free) ||
                    ((state == S_HOLD) && out_free);

  // prefetch the next lower slot while the current one is processed
  assign rd_addr = (state == S_WALK && idx != '0) ? idx - IW'(1) : TOP;

  xlb_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (VALUE_BITS),
    .AW    (IW)
  ) u_basis (
    .clk   (clk),
    .we    (wr_en),
    .waddr (idx),
    .wdata (acc),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign slot = slot_valid[idx] ? rd_data : '0;

  always_comb begin
    wr_en     = 1'b0;
    acc_next  = acc;
    walk_done = (idx == '0);
    if (state == S_WALK) begin
      if (op_query) begin
        // slot idx has its top bit at idx, so xor only helps when that bit is clear
        if (!acc[idx]) begin
          acc_next = acc ^ slot;
        end
      end else if (acc[idx]) begin
        if (!slot_valid[idx]) begin
          wr_en     = 1'b1;
          walk_done = 1'b1;
        end else begin
          acc_next = acc ^ slot;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (req.command == CMD_INSERT || req.command == CMD_QUERY) begin
              state <= S_WALK;
            end else if (req.command == CMD_CLEAR) begin
              slot_valid <= '0;
            end
          end
        end
        S_WALK: begin
          if (wr_en) begin
            slot_valid[idx] <= 1'b1;
          end
          if (walk_done) begin
            if (!op_query || out_free) begin
              state <= S_IDLE;
            end else begin
              state <= S_HOLD;
            end
          end
        end
        S_HOLD: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.valid && rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // datapath registers, no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      acc      <= VALUE_BITS'(req.value);
      op_query <= (req.command == CMD_QUERY);
      idx      <= TOP;
    end else if (state == S_WALK) begin
      acc <= acc_next;
      if (!walk_done) begin
        idx <= idx - IW'(1);
      end
      if (walk_done && op_query && out_free) begin
        out_data <= acc_next;
      end
    end else if (state == S_HOLD && out_free) begin
      out_data <= acc;
    end
  end

  // a stored vector always has its leading bit at its slot
  a_store_leading_bit: assert property (@(posedge clk) disable iff (rst)
    wr_en |-> acc[idx] && !slot_valid[idx])
    else $error("basis write without leading bit at slot");

  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    accept && req.command == CMD_CLEAR |=> slot_valid == '0)
    else $error("clear left a slot valid");

  a_hold_needs_full_out: assert property (@(posedge clk) disable iff (rst)
    state == S_HOLD |-> out_valid)
    else $error("result held while output register empty");

  a_walk_no_new_item: assert property (@(posedge clk) disable iff (rst)
    state == S_WALK && !walk_done |=> state == S_WALK)
    else $error("walk left before the last slot");

endmodule

`default_nettype wire
